// ===== src/nrb_pkg.sv =====
// Shared types and constants for the generic NACK report builder.
package nrb_pkg;

  localparam int unsigned MAX_PACKET_BYTES_DEF = 1500;

  localparam int SEQ_W    = 16;
  localparam int MASK_W   = 16;
  localparam int COUNT_W  = 8;
  localparam int OFFSET_W = 11;
  localparam int SUM_W    = 16;

  localparam logic [COUNT_W-1:0]  FIELD_CAP    = 8'd253;
  localparam logic [SEQ_W:0]      SPAN         = 17'd16;
  localparam logic [SUM_W-1:0]    HEADER_BYTES = 16'd12;
  localparam logic [SUM_W-1:0]    MIN_REPORT   = 16'd16;
  localparam logic [COUNT_W-1:0]  BASE_LENGTH  = 8'd2;
  localparam logic [OFFSET_W-1:0] OFFSET_RST   = 11'd0;
  localparam logic [COUNT_W-1:0]  FIELDS_RST   = 8'd253;

  typedef enum logic {
    REG_START_OFFSET = 1'b0,
    REG_MAX_FIELDS   = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    KIND_ENTRY   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic             has_seq;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [SEQ_W-1:0]  pid;
    logic [MASK_W-1:0] blp;
    logic [COUNT_W-1:0] length_words;
    logic              status;
    logic              end_of_run;
  } out_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] start_offset;
    logic [COUNT_W-1:0]  max_fields;
  } cfg_t;

  // Up to three results from one request: the entry it closes, the entry
  // left open at the end of the list, and the summary.
  typedef struct packed {
    logic [2:0]         emit;
    logic [SEQ_W-1:0]   closed_pid;
    logic [MASK_W-1:0]  closed_blp;
    logic [SEQ_W-1:0]   open_pid;
    logic [MASK_W-1:0]  open_blp;
    logic [COUNT_W-1:0] length_words;
    logic               status;
  } bundle_t;

  localparam int EMIT_CLOSED  = 0;
  localparam int EMIT_OPEN    = 1;
  localparam int EMIT_SUMMARY = 2;

endpackage

// ===== src/nrb_stream_if.sv =====
// Valid/ready stream channel carrying one payload item.
interface nrb_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/nrb_entry_builder.sv =====
// Input register, list state and per-request entry grouping logic.
module nrb_entry_builder #(
  parameter int unsigned MAX_PACKET_BYTES = nrb_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  nrb_stream_if.sink       lost,
  input  nrb_pkg::cfg_t    cfg,
  input  logic             bundle_free,
  output logic             bundle_load,
  output nrb_pkg::bundle_t bundle
);

  localparam logic [nrb_pkg::SUM_W-1:0] MaxBytes = nrb_pkg::SUM_W'(MAX_PACKET_BYTES);

  logic               in_valid;
  nrb_pkg::in_item_t  in_item;
  logic               advance;

  logic [nrb_pkg::SEQ_W-1:0]   base_number, base_number_next;
  logic [nrb_pkg::MASK_W-1:0]  loss_mask, loss_mask_next;
  logic                        entry_open, entry_open_next;
  logic [nrb_pkg::COUNT_W-1:0] entry_count, entry_count_next;
  logic                        size_error, size_error_next;
  logic                        limit_reached, limit_reached_next;

  logic                        take;
  logic                        in_range;
  logic [nrb_pkg::SEQ_W-1:0]   offset_diff;
  logic [nrb_pkg::COUNT_W-1:0] limit;
  logic [nrb_pkg::COUNT_W:0]   count_inc;
  logic [nrb_pkg::SUM_W-1:0]   need_bytes;
  logic                        summary_error;

  assign advance    = in_valid && ((bundle.emit == 3'b000) || bundle_free);
  assign lost.ready = !in_valid || advance;
  assign bundle_load = in_valid && (bundle.emit != 3'b000) && bundle_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (lost.ready) begin
      in_valid <= lost.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lost.ready && lost.valid) begin
      in_item <= lost.data;
    end
  end

  assign limit = (cfg.max_fields < nrb_pkg::FIELD_CAP) ? cfg.max_fields : nrb_pkg::FIELD_CAP;
  assign count_inc = {1'b0, entry_count} + 9'd1;
  assign need_bytes = nrb_pkg::SUM_W'(cfg.start_offset) + nrb_pkg::HEADER_BYTES
                    + nrb_pkg::SUM_W'({count_inc, 2'b00});
  assign take = in_item.has_seq && !size_error && !limit_reached;
  assign in_range = entry_open && (in_item.seq > base_number)
                  && ({1'b0, in_item.seq} < ({1'b0, base_number} + nrb_pkg::SPAN));
  assign offset_diff = in_item.seq - base_number - 16'd1;

  always_comb begin
    base_number_next   = base_number;
    loss_mask_next     = loss_mask;
    entry_open_next    = entry_open;
    entry_count_next   = entry_count;
    size_error_next    = size_error;
    limit_reached_next = limit_reached;
    summary_error      = 1'b0;

    bundle.emit         = 3'b000;
    bundle.closed_pid   = base_number;
    bundle.closed_blp   = loss_mask;
    bundle.open_pid     = '0;
    bundle.open_blp     = '0;
    bundle.length_words = '0;
    bundle.status       = 1'b0;

    if (take) begin
      if (in_range) begin
        loss_mask_next = loss_mask | (16'd1 << offset_diff[3:0]);
      end else begin
        bundle.emit[nrb_pkg::EMIT_CLOSED] = entry_open;
        entry_open_next = 1'b0;
        loss_mask_next  = '0;
        priority if (entry_count >= limit) begin
          limit_reached_next = 1'b1;
        end else if (need_bytes > MaxBytes) begin
          size_error_next = 1'b1;
        end else begin
          entry_count_next = count_inc[nrb_pkg::COUNT_W-1:0];
          base_number_next = in_item.seq;
          entry_open_next  = 1'b1;
        end
      end
    end

    if (in_item.last) begin
      bundle.emit[nrb_pkg::EMIT_OPEN]    = entry_open_next;
      bundle.emit[nrb_pkg::EMIT_SUMMARY] = 1'b1;
      bundle.open_pid = base_number_next;
      bundle.open_blp = loss_mask_next;
      summary_error = size_error_next
                    || ((nrb_pkg::SUM_W'(cfg.start_offset) + nrb_pkg::MIN_REPORT) > MaxBytes);
      bundle.length_words = nrb_pkg::BASE_LENGTH + entry_count_next;
      bundle.status       = summary_error;
      // clear list state for the next list
      base_number_next   = '0;
      loss_mask_next     = '0;
      entry_open_next    = 1'b0;
      entry_count_next   = '0;
      size_error_next    = 1'b0;
      limit_reached_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_number   <= '0;
      loss_mask     <= '0;
      entry_open    <= 1'b0;
      entry_count   <= '0;
      size_error    <= 1'b0;
      limit_reached <= 1'b0;
    end else if (advance) begin
      base_number   <= base_number_next;
      loss_mask     <= loss_mask_next;
      entry_open    <= entry_open_next;
      entry_count   <= entry_count_next;
      size_error    <= size_error_next;
      limit_reached <= limit_reached_next;
    end
  end

endmodule

// ===== src/nrb_result_serializer.sv =====
// Result register: holds one request's results and hands them out in order.
module nrb_result_serializer (
  input  logic             clk,
  input  logic             rst,
  input  logic             bundle_load,
  input  nrb_pkg::bundle_t bundle,
  output logic             bundle_free,
  nrb_stream_if.source     report
);

  nrb_pkg::bundle_t held;
  logic [2:0]       pending;
  logic [2:0]       rest;
  logic             take;

  assign take = report.valid && report.ready;
  // drop the lowest pending result
  assign rest = pending & (pending - 3'd1);
  assign bundle_free = (pending == 3'b000) || (take && (rest == 3'b000));
  assign report.valid = (pending != 3'b000);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'b000;
    end else if (bundle_load) begin
      pending <= bundle.emit;
    end else if (take) begin
      pending <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (bundle_load) begin
      held <= bundle;
    end
  end

  always_comb begin
    report.data.kind         = nrb_pkg::KIND_ENTRY;
    report.data.pid          = '0;
    report.data.blp          = '0;
    report.data.length_words = '0;
    report.data.status       = 1'b0;
    report.data.end_of_run   = 1'b0;
    priority if (pending[nrb_pkg::EMIT_CLOSED]) begin
      report.data.pid = held.closed_pid;
      report.data.blp = held.closed_blp;
    end else if (pending[nrb_pkg::EMIT_OPEN]) begin
      report.data.pid = held.open_pid;
      report.data.blp = held.open_blp;
    end else if (pending[nrb_pkg::EMIT_SUMMARY]) begin
      report.data.kind         = nrb_pkg::KIND_SUMMARY;
      report.data.length_words = held.length_words;
      report.data.status       = held.status;
      report.data.end_of_run   = 1'b1;
    end else begin
      report.data.kind = nrb_pkg::KIND_ENTRY;
    end
  end

endmodule

// ===== src/nack_report_builder.sv =====
// Top level of the generic NACK report builder with its register port.
//
//   channel   dir   payload                                      handshake
//   lost      in    seq, has_seq, last                           valid/ready
//   report    out   kind, pid, blp, length_words, status, eor    valid/ready
//   wr_*      in    wr_index, wr_data                            wr_en, no wait
//
// A request is captured in the input register; its results move into the result
// register once it is free, and a new request is taken every cycle unless one
// with results waits. A request with n results holds the result register until
// all n are taken (n is at most three: closed entry, open entry, summary).
// Reset clears the list state, the valid flags and loads the register defaults.
// A stalled report stalls the input register once it holds a request with results, which then drops lost.ready.
module nack_report_builder #(
  parameter int unsigned MAX_PACKET_BYTES = nrb_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  nrb_stream_if.sink                    lost,
  nrb_stream_if.source                  report,
  input  logic                          wr_en,
  input  logic                          wr_index,
  input  logic [nrb_pkg::OFFSET_W-1:0]  wr_data
);

  nrb_pkg::cfg_t    cfg;
  nrb_pkg::bundle_t bundle;
  logic             bundle_load;
  logic             bundle_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_offset <= nrb_pkg::OFFSET_RST;
      cfg.max_fields   <= nrb_pkg::FIELDS_RST;
    end else if (wr_en) begin
      unique case (nrb_pkg::cfg_reg_e'(wr_index))
        nrb_pkg::REG_START_OFFSET: cfg.start_offset <= wr_data;
        nrb_pkg::REG_MAX_FIELDS:   cfg.max_fields   <= wr_data[nrb_pkg::COUNT_W-1:0];
        default:                   cfg.max_fields   <= cfg.max_fields;
      endcase
    end
  end

  nrb_entry_builder #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_builder (
    .clk        (clk),
    .rst        (rst),
    .lost       (lost),
    .cfg        (cfg),
    .bundle_free(bundle_free),
    .bundle_load(bundle_load),
    .bundle     (bundle)
  );

  nrb_result_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .bundle_load(bundle_load),
    .bundle     (bundle),
    .bundle_free(bundle_free),
    .report     (report)
  );

endmodule
